// ----- rtl/core/hs_pkg.sv -----
// Shared types and constants for the heap sorter.
// Depends on nothing; every other file of the block but hs_ram imports it.
`timescale 1ns / 1ps

package hs_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    // Counts run up to CAPACITY itself; child indices run up to 2*CAPACITY.
    localparam int CNT_W    = ADDR_W + 1;
    localparam int IDX_W    = ADDR_W + 2;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [ADDR_W-1:0]  t_addr;
    typedef logic        [CNT_W-1:0]   t_count;
    typedef logic        [IDX_W-1:0]   t_index;

    // One result word offered by the sequencer to the output register.
    typedef struct packed {
        logic   valid;
        t_value sorted_value;
        logic   final_result;
        logic   set_overflowed;
    } t_emit;

    // Write and read requests toward the element memory.
    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_value wdata;
        logic   re;
        t_addr  raddr;
    } t_mem_cmd;

endpackage

// ----- rtl/core/hs_if.sv -----
// Valid/ready channel interfaces for the input and result words of the heap sorter.
// Depends on hs_pkg for the payload types.
`timescale 1ns / 1ps

interface hs_in_if import hs_pkg::*;;
    logic   valid;
    logic   ready;
    t_value sample_value;
    logic   end_of_set;

    modport source (output valid, output sample_value, output end_of_set, input ready);
    modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface hs_out_if import hs_pkg::*;;
    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   final_result;
    logic   set_overflowed;

    modport source (output valid, output sorted_value, output final_result,
                    output set_overflowed, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input set_overflowed, output ready);
endinterface

// ----- rtl/core/hs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hs_ctrl.sv -----
// Heap sorter sequencer: collects words, builds and drains the max-heap with one
// shared signed comparator, and reads the sorted set out. Depends on hs_pkg, hs_if.
`timescale 1ns / 1ps

module hs_ctrl import hs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hs_in_if.sink    i_in,
    output t_emit    o_emit,
    input  logic     i_take,
    output t_mem_cmd o_mem,
    input  t_value   i_rdata
);

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_LOADW   = 4'd2;
    localparam logic [3:0] S_RD_L    = 4'd3;
    localparam logic [3:0] S_RD_R    = 4'd4;
    localparam logic [3:0] S_CMP_C   = 4'd5;
    localparam logic [3:0] S_CMP_V   = 4'd6;
    localparam logic [3:0] S_X_RD0   = 4'd7;
    localparam logic [3:0] S_X_RDE   = 4'd8;
    localparam logic [3:0] S_X_WR    = 4'd9;
    localparam logic [3:0] S_E_RD    = 4'd10;
    localparam logic [3:0] S_E_CAP   = 4'd11;

    localparam t_count CAP_CNT = CNT_W'(CAPACITY);

    logic [3:0] r_state, n_state;
    t_count     r_count, n_count;
    logic       r_ovf,   n_ovf;
    logic       r_build, n_build;
    t_addr      r_k,     n_k;
    t_count     r_len,   n_len;
    t_addr      r_end,   n_end;
    t_addr      r_node,  n_node;
    t_addr      r_child, n_child;
    t_addr      r_i,     n_i;
    t_value     r_v,     n_v;
    t_value     r_cl,    n_cl;
    t_value     r_cv,    n_cv;
    t_value     r_top,   n_top;

    t_value cmp_a;
    t_value cmp_b;
    logic   cmp_lt;
    t_index w_lc;
    t_index w_rc;
    t_index w_len_x;
    logic   w_has_l;
    logic   w_has_r;
    logic   w_accept;
    logic   w_room;
    t_count w_new_count;
    t_count w_half;
    t_count w_nm1;
    logic   w_last_i;
    logic   w_sift_done;

    assign w_lc        = {1'b0, r_node, 1'b1};
    assign w_rc        = w_lc + IDX_W'(1);
    assign w_len_x     = {1'b0, r_len};
    assign w_has_l     = w_lc < w_len_x;
    assign w_has_r     = w_rc < w_len_x;
    assign i_in.ready  = (r_state == S_COLLECT);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_room      = r_count < CAP_CNT;
    assign w_new_count = r_count + CNT_W'(w_room);
    assign w_half      = (w_new_count - CNT_W'(2)) >> 1;
    assign w_nm1       = w_new_count - CNT_W'(1);
    assign w_last_i    = (({1'b0, r_i} + CNT_W'(1)) == r_count);

    // The one comparator: child against child, then the moving value against a child.
    always_comb begin
        if (r_state == S_CMP_C) begin
            cmp_a = r_cl;
            cmp_b = i_rdata;
        end else begin
            cmp_a = r_v;
            cmp_b = r_cv;
        end
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_build     = r_build;
        n_k         = r_k;
        n_len       = r_len;
        n_end       = r_end;
        n_node      = r_node;
        n_child     = r_child;
        n_i         = r_i;
        n_v         = r_v;
        n_cl        = r_cl;
        n_cv        = r_cv;
        n_top       = r_top;
        w_sift_done = 1'b0;
        o_mem       = '0;
        o_emit      = '0;

        unique case (r_state)
            S_COLLECT: begin
                if (w_accept) begin
                    o_mem.we    = w_room;
                    o_mem.waddr = r_count[ADDR_W-1:0];
                    o_mem.wdata = i_in.sample_value;
                    n_count     = w_new_count;
                    n_ovf       = r_ovf || !w_room;
                    if (i_in.end_of_set) begin
                        if (w_new_count < CNT_W'(2)) begin
                            n_i     = '0;
                            n_state = S_E_RD;
                        end else begin
                            n_len   = w_new_count;
                            n_k     = w_half[ADDR_W-1:0];
                            n_end   = w_nm1[ADDR_W-1:0];
                            n_build = 1'b1;
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_k;
                n_state     = S_LOADW;
            end
            S_LOADW: begin
                n_v     = i_rdata;
                n_node  = r_k;
                n_state = S_RD_L;
            end
            S_RD_L: begin
                if (w_has_l) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = w_lc[ADDR_W-1:0];
                    n_state     = S_RD_R;
                end else begin
                    // Leaf reached: the moving value settles in the hole.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_node;
                    o_mem.wdata = r_v;
                    w_sift_done = 1'b1;
                end
            end
            S_RD_R: begin
                n_cl    = i_rdata;
                n_cv    = i_rdata;
                n_child = w_lc[ADDR_W-1:0];
                if (w_has_r) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = w_rc[ADDR_W-1:0];
                    n_state     = S_CMP_C;
                end else begin
                    n_state = S_CMP_V;
                end
            end
            S_CMP_C: begin
                // The right child wins only when strictly larger than the left.
                if (cmp_lt) begin
                    n_cv    = i_rdata;
                    n_child = w_rc[ADDR_W-1:0];
                end
                n_state = S_CMP_V;
            end
            S_CMP_V: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_node;
                if (cmp_lt) begin
                    o_mem.wdata = r_cv;
                    n_node      = r_child;
                    n_state     = S_RD_L;
                end else begin
                    o_mem.wdata = r_v;
                    w_sift_done = 1'b1;
                end
            end
            S_X_RD0: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = '0;
                n_state     = S_X_RDE;
            end
            S_X_RDE: begin
                n_top       = i_rdata;
                o_mem.re    = 1'b1;
                o_mem.raddr = r_end;
                n_state     = S_X_WR;
            end
            S_X_WR: begin
                // The old root goes to the end; the old end word sifts down from the root.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_end;
                o_mem.wdata = r_top;
                n_v         = i_rdata;
                n_node      = '0;
                n_len       = {1'b0, r_end};
                n_state     = S_RD_L;
            end
            S_E_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_i;
                n_state     = S_E_CAP;
            end
            S_E_CAP: begin
                o_emit.valid          = 1'b1;
                o_emit.sorted_value   = i_rdata;
                o_emit.final_result   = w_last_i;
                o_emit.set_overflowed = r_ovf;
                if (i_take) begin
                    if (w_last_i) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_COLLECT;
                    end else begin
                        n_i     = r_i + ADDR_W'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase

        if (w_sift_done) begin
            if (r_build) begin
                if (r_k == '0) begin
                    n_build = 1'b0;
                    n_state = S_X_RD0;
                end else begin
                    n_k     = r_k - ADDR_W'(1);
                    n_state = S_LOAD;
                end
            end else begin
                if (r_end == ADDR_W'(1)) begin
                    n_i     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_end   = r_end - ADDR_W'(1);
                    n_state = S_X_RD0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_build <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_build <= n_build;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_len   <= n_len;
        r_end   <= n_end;
        r_node  <= n_node;
        r_child <= n_child;
        r_i     <= n_i;
        r_v     <= n_v;
        r_cl    <= n_cl;
        r_cv    <= n_cv;
        r_top   <= n_top;
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("stored count exceeds capacity");

    a_close_leaves_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.end_of_set) |=> (r_state != S_COLLECT))
        else $error("closing word did not start the sort");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.we && o_mem.re && (o_mem.waddr == o_mem.raddr)))
        else $error("read and write of the same entry in one cycle");

    a_final_clears_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && i_take && o_emit.final_result)
            |=> (r_count == '0 && !r_ovf && r_state == S_COLLECT))
        else $error("set not cleared after its final word");

endmodule

// ----- rtl/core/heap_sorter.sv -----
// Heap sorter, top level: ties the sequencer, the element RAM and the result register.
// Depends on hs_pkg, hs_if, hs_ram and hs_ctrl.
//
// Words are taken one per cycle into a 64-entry store until a word marked end_of_set
// closes the set; words beyond capacity are dropped and flag every result of that set
// as overflowed. The set is then heapsorted in place and read out in ascending order,
// the largest word carrying final_result. Input is not ready from the closing word
// until the final result has been loaded into the output register. The one signed
// comparator and the single read port of the store handle one heap level at a time:
// read the left child, read the right child if there is one, compare the children,
// then compare the moving word with the larger child and write the node. Read-out
// reads each word from the store, offers it to the output register and moves on
// to the next word only once that word is taken.
`timescale 1ns / 1ps

module heap_sorter import hs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hs_in_if.sink    i_in,
    hs_out_if.source o_out
);

    t_emit    emit;
    t_mem_cmd mem_cmd;
    logic     take;
    logic     [VALUE_W-1:0] rdata_raw;

    logic     r_out_valid;
    t_value   r_out_value;
    logic     r_out_final;
    logic     r_out_ovf;

    hs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_emit  (emit),
        .i_take  (take),
        .o_mem   (mem_cmd),
        .i_rdata (t_value'(rdata_raw))
    );

    hs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_cmd.we),
        .i_waddr (mem_cmd.waddr),
        .i_wdata (mem_cmd.wdata),
        .i_re    (mem_cmd.re),
        .i_raddr (mem_cmd.raddr),
        .o_rdata (rdata_raw)
    );

    // The result register loads whenever it is empty or its word is being taken.
    assign take = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit.valid) begin
            r_out_value <= emit.sorted_value;
            r_out_final <= emit.final_result;
            r_out_ovf   <= emit.set_overflowed;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sorted_value   = r_out_value;
    assign o_out.final_result   = r_out_final;
    assign o_out.set_overflowed = r_out_ovf;

endmodule
